// File: hdl/obhs_pkg.sv
package obhs_pkg;

   localparam int VAL_W      = 16;
   localparam int ADDR_W     = 17;
   localparam int COORD_W    = 32;
   localparam int GAIN_W     = 32;
   localparam int GAIN_FRAC  = 16;
   localparam int HEIGHT_W   = 32;
   localparam int PACKS_REG_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PACK_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_GAIN = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 32'sh7fff_ffff;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 32'sh8000_0000;

   // four texels around one sample point, row-major
   typedef struct packed {
      logic signed [VAL_W-1:0] t00;
      logic signed [VAL_W-1:0] t01;
      logic signed [VAL_W-1:0] t10;
      logic signed [VAL_W-1:0] t11;
   } texel_quad_type;

endpackage

// File: hdl/obhs_req_if.sv
interface obhs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic        [obhs_pkg::ADDR_W-1:0]    entry_address;
   logic signed [obhs_pkg::VAL_W-1:0]     entry_value;
   logic        [obhs_pkg::COORD_W-1:0]   coord_u;
   logic        [obhs_pkg::COORD_W-1:0]   coord_v;

   modport source (output valid, action, entry_address, entry_value, coord_u, coord_v,
                   input ready);
   modport sink   (input valid, action, entry_address, entry_value, coord_u, coord_v,
                   output ready);
endinterface

// File: hdl/obhs_rsp_if.sv
interface obhs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [obhs_pkg::HEIGHT_W-1:0]  height;

   modport source (output valid, height, input ready);
   modport sink   (input valid, height, output ready);
endinterface

// File: hdl/octave_bilinear_height_sample_unit.sv
// Octave bilinear height sampler.
// req_chan carries one transaction per item. action 0 writes entry_value into
// the noise tile store at entry_address (addresses past the store are
// dropped); writes may follow back to back. action 1 samples the height at
// (coord_u, coord_v): for each active pack the four neighboring texels
// come from a four-bank store in one read, and one shared interpolation
// multiplier runs three times (top row, bottom row, vertical blend) before
// the sum is updated. Each pack steps through FETCH, TOP, BOT, VAL and ACC;
// the sample ends in MUL and SAT, and SAT loads height into the output
// register. req_chan.ready is low while a sample is in flight.
// rsp_chan is driven from an output register; a stalled receiver does not
// block writes or the start of the next sample, which holds in its final
// step until the register frees up. csr_* writes pack_count (index 0) and
// height_gain (index 1); the user must write them only while idle, as the
// block itself does not enforce it. Synchronous reset clears the sequencer,
// the output valid, pack_count to 0 and height_gain to 1.0; tile contents
// are undefined until written.
module octave_bilinear_height_sample_unit #(
   parameter int TILE_SIZE_LOG2 = 7,
   parameter int FRAC_BITS      = 12,
   parameter int PACK_SHIFT     = 3,
   parameter int MAX_PACKS      = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [obhs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [obhs_pkg::CSR_DATA_W-1:0]      csr_write_data,
   obhs_req_if.sink                             req_chan,
   obhs_rsp_if.source                           rsp_chan
);

   localparam int PACK_W = (MAX_PACKS > 1) ? $clog2(MAX_PACKS) : 1;
   localparam int CNT_W  = $clog2(MAX_PACKS + 1);
   localparam int SUM_W  = obhs_pkg::VAL_W + ((MAX_PACKS > 1) ? $clog2(MAX_PACKS) : 0);
   localparam int unsigned STORE_DEPTH = MAX_PACKS * (2 ** (2 * TILE_SIZE_LOG2));
   localparam int TS     = TILE_SIZE_LOG2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_TOP,
      ST_BOT,
      ST_VAL,
      ST_ACC,
      ST_MUL,
      ST_SAT
   } state_type;

   state_type                               state_ff;
   logic [obhs_pkg::PACKS_REG_W-1:0]        pack_count_ff;
   logic [obhs_pkg::GAIN_W-1:0]             height_gain_ff;
   logic [obhs_pkg::COORD_W-1:0]            u_ff;
   logic [obhs_pkg::COORD_W-1:0]            v_ff;
   logic [CNT_W-1:0]                        packs_ff;
   logic [CNT_W-1:0]                        pack_idx_ff;
   logic signed [SUM_W-1:0]                 sum_ff;
   logic signed [obhs_pkg::VAL_W-1:0]       top_ff;
   logic                                    rsp_valid_ff;
   logic signed [obhs_pkg::HEIGHT_W-1:0]    rsp_height_ff;

   logic                                    req_accept;
   logic [CNT_W-1:0]                        packs_in;
   logic [31:0]                             wr_addr_ext;
   logic [31:0]                             wr_pack_full;
   logic                                    store_wr_en;
   logic                                    store_rd_en;
   obhs_pkg::texel_quad_type                quad;
   logic                                    lerp_load;
   logic signed [obhs_pkg::VAL_W-1:0]       lerp_a;
   logic signed [obhs_pkg::VAL_W-1:0]       lerp_b;
   logic [FRAC_BITS-1:0]                    lerp_frac;
   logic signed [obhs_pkg::VAL_W-1:0]       lerp_q;
   logic signed [obhs_pkg::HEIGHT_W-1:0]    scaled_height;
   logic                                    rsp_free;
   logic                                    rsp_load;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.height = rsp_height_ff;
   assign rsp_free        = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load        = (state_ff == ST_SAT) && rsp_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pack_count_ff  <= '0;
         height_gain_ff <= obhs_pkg::GAIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            obhs_pkg::CSR_PACK_COUNT:  pack_count_ff  <= csr_write_data[obhs_pkg::PACKS_REG_W-1:0];
            obhs_pkg::CSR_HEIGHT_GAIN: height_gain_ff <= csr_write_data[obhs_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign packs_in = (32'(pack_count_ff) > MAX_PACKS) ? CNT_W'(MAX_PACKS)
                                                       : CNT_W'(pack_count_ff);

   // tile write decode
   assign wr_addr_ext  = 32'(req_chan.entry_address);
   assign wr_pack_full = wr_addr_ext >> (2 * TS);
   assign store_wr_en  = req_accept && !req_chan.action && (wr_addr_ext < STORE_DEPTH);
   assign store_rd_en  = (state_ff == ST_FETCH);

   obhs_texel_store #(
      .TILE_SIZE_LOG2 (TILE_SIZE_LOG2),
      .PACK_W         (PACK_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_pack (wr_pack_full[PACK_W-1:0]),
      .wr_row  (wr_addr_ext[2*TS-1:TS]),
      .wr_col  (wr_addr_ext[TS-1:0]),
      .wr_data (req_chan.entry_value),
      .rd_en   (store_rd_en),
      .rd_pack (pack_idx_ff[PACK_W-1:0]),
      .rd_row  (v_ff[FRAC_BITS+TS-1:FRAC_BITS]),
      .rd_col  (u_ff[FRAC_BITS+TS-1:FRAC_BITS]),
      .quad    (quad)
   );

   // operand select for the shared interpolation unit
   always_comb begin
      lerp_load = 1'b0;
      lerp_a    = quad.t00;
      lerp_b    = quad.t01;
      lerp_frac = u_ff[FRAC_BITS-1:0];
      case (state_ff)
         ST_TOP: begin
            lerp_load = 1'b1;
         end
         ST_BOT: begin
            lerp_load = 1'b1;
            lerp_a    = quad.t10;
            lerp_b    = quad.t11;
         end
         ST_VAL: begin
            lerp_load = 1'b1;
            lerp_a    = top_ff;
            lerp_b    = lerp_q;
            lerp_frac = v_ff[FRAC_BITS-1:0];
         end
         default: ;
      endcase
   end

   obhs_lerp_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock     (clock),
      .load      (lerp_load),
      .a         (lerp_a),
      .b         (lerp_b),
      .frac      (lerp_frac),
      .result_ff (lerp_q)
   );

   obhs_gain_scale #(
      .SUM_W (SUM_W)
   ) u_gain (
      .clock  (clock),
      .sum    (sum_ff),
      .gain   (height_gain_ff),
      .height (scaled_height)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pack_idx_ff  <= '0;
         packs_ff     <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_chan.action) begin
                  u_ff        <= req_chan.coord_u;
                  v_ff        <= req_chan.coord_v;
                  packs_ff    <= packs_in;
                  pack_idx_ff <= '0;
                  sum_ff      <= '0;
                  state_ff    <= (packs_in == '0) ? ST_MUL : ST_FETCH;
               end
            end
            ST_FETCH: state_ff <= ST_TOP;
            ST_TOP:   state_ff <= ST_BOT;
            ST_BOT: begin
               top_ff   <= lerp_q;
               state_ff <= ST_VAL;
            end
            ST_VAL:   state_ff <= ST_ACC;
            ST_ACC: begin
               sum_ff      <= sum_ff + SUM_W'(lerp_q);
               u_ff        <= u_ff << PACK_SHIFT;
               v_ff        <= v_ff << PACK_SHIFT;
               pack_idx_ff <= pack_idx_ff + 1'b1;
               state_ff    <= (pack_idx_ff == packs_ff - 1'b1) ? ST_MUL : ST_FETCH;
            end
            ST_MUL:   state_ff <= ST_SAT;
            ST_SAT: begin
               // hold until the output register is free
               if (rsp_load) begin
                  rsp_height_ff <= scaled_height;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.action |=> state_ff == ST_FETCH || state_ff == ST_MUL)
      else $error("sample did not start the pack sequence");

   a_pack_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> pack_idx_ff <= packs_ff)
      else $error("pack index ran past the pack count");

   a_rsp_from_sat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SAT)
      else $error("response raised outside the final step");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> state_ff == ST_IDLE && !store_rd_en)
      else $error("tile write during a sample");
`endif

endmodule

// File: hdl/obhs_texel_store.sv
module obhs_texel_store #(
   parameter int TILE_SIZE_LOG2 = 7,
   parameter int PACK_W         = 3
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [PACK_W-1:0]                    wr_pack,
   input  logic [TILE_SIZE_LOG2-1:0]            wr_row,
   input  logic [TILE_SIZE_LOG2-1:0]            wr_col,
   input  logic signed [obhs_pkg::VAL_W-1:0]    wr_data,
   input  logic                                 rd_en,
   input  logic [PACK_W-1:0]                    rd_pack,
   input  logic [TILE_SIZE_LOG2-1:0]            rd_row,
   input  logic [TILE_SIZE_LOG2-1:0]            rd_col,
   output obhs_pkg::texel_quad_type             quad
);

   localparam int BANK_AW    = PACK_W + 2 * TILE_SIZE_LOG2 - 2;
   localparam int BANK_DEPTH = 2 ** BANK_AW;

   logic [TILE_SIZE_LOG2-1:0]         rd_row_next;
   logic [TILE_SIZE_LOG2-1:0]         rd_col_next;
   logic signed [obhs_pkg::VAL_W-1:0] bank_q [4];
   logic [1:0]                        parity_ff;

   // wrap to the first row and column of the tile
   assign rd_row_next = rd_row + 1'b1;
   assign rd_col_next = rd_col + 1'b1;

   // each bank holds one row parity and one column parity, so the four
   // neighbors always fall into four different banks
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam bit ROW_PAR = 1'((b >> 1) & 1);
      localparam bit COL_PAR = 1'(b & 1);

      logic signed [obhs_pkg::VAL_W-1:0] mem [BANK_DEPTH];
      logic signed [obhs_pkg::VAL_W-1:0] rdata_ff;
      logic [TILE_SIZE_LOG2-1:0]         row_sel;
      logic [TILE_SIZE_LOG2-1:0]         col_sel;
      logic [BANK_AW-1:0]                rd_addr;
      logic [BANK_AW-1:0]                wr_addr;

      assign row_sel = (rd_row[0] == ROW_PAR) ? rd_row : rd_row_next;
      assign col_sel = (rd_col[0] == COL_PAR) ? rd_col : rd_col_next;
      assign rd_addr = {rd_pack, row_sel[TILE_SIZE_LOG2-1:1], col_sel[TILE_SIZE_LOG2-1:1]};
      assign wr_addr = {wr_pack, wr_row[TILE_SIZE_LOG2-1:1], wr_col[TILE_SIZE_LOG2-1:1]};

      always_ff @(posedge clock) begin
         if (wr_en && wr_row[0] == ROW_PAR && wr_col[0] == COL_PAR) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rdata_ff <= mem[rd_addr];
         end
      end

      assign bank_q[b] = rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         parity_ff <= {rd_row[0], rd_col[0]};
      end
   end

   assign quad.t00 = bank_q[{ parity_ff[1],  parity_ff[0]}];
   assign quad.t01 = bank_q[{ parity_ff[1], ~parity_ff[0]}];
   assign quad.t10 = bank_q[{~parity_ff[1],  parity_ff[0]}];
   assign quad.t11 = bank_q[{~parity_ff[1], ~parity_ff[0]}];

endmodule

// File: hdl/obhs_lerp_unit.sv
module obhs_lerp_unit #(
   parameter int FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               load,
   input  logic signed [obhs_pkg::VAL_W-1:0]  a,
   input  logic signed [obhs_pkg::VAL_W-1:0]  b,
   input  logic [FRAC_BITS-1:0]               frac,
   output logic signed [obhs_pkg::VAL_W-1:0]  result_ff
);

   localparam int DIFF_W = obhs_pkg::VAL_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
   localparam int STEP_W = DIFF_W + 1;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_shifted;
   logic signed [STEP_W-1:0] step;
   logic signed [STEP_W-1:0] total;

   // (S-f)*a + f*b over S equals a + f*(b-a) over S, floored
   assign diff         = {b[obhs_pkg::VAL_W-1], b} - {a[obhs_pkg::VAL_W-1], a};
   assign prod         = diff * $signed({1'b0, frac});
   assign prod_shifted = prod >>> FRAC_BITS;
   assign step         = prod_shifted[STEP_W-1:0];
   assign total        = {{(STEP_W-obhs_pkg::VAL_W){a[obhs_pkg::VAL_W-1]}}, a} + step;

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= total[obhs_pkg::VAL_W-1:0];
      end
   end

endmodule

// File: hdl/obhs_gain_scale.sv
module obhs_gain_scale #(
   parameter int SUM_W = 19
) (
   input  logic                                  clock,
   input  logic signed [SUM_W-1:0]               sum,
   input  logic [obhs_pkg::GAIN_W-1:0]           gain,
   output logic signed [obhs_pkg::HEIGHT_W-1:0]  height
);

   localparam int PROD_W = SUM_W + obhs_pkg::GAIN_W + 1;
   localparam int LOW    = obhs_pkg::GAIN_FRAC;
   localparam int TOP    = LOW + obhs_pkg::HEIGHT_W - 1;

   logic signed [PROD_W-1:0] product_ff;
   logic [PROD_W-1-TOP:0]    high_bits;

   always_ff @(posedge clock) begin
      product_ff <= sum * $signed({1'b0, gain});
   end

   // in range when every bit from the result sign upward agrees
   assign high_bits = product_ff[PROD_W-1:TOP];

   always_comb begin
      if (&high_bits || ~|high_bits) begin
         height = product_ff[TOP:LOW];
      end else if (product_ff[PROD_W-1]) begin
         height = obhs_pkg::HEIGHT_MIN;
      end else begin
         height = obhs_pkg::HEIGHT_MAX;
      end
   end

endmodule

// File: tb/octave_bilinear_height_sample_unit_test.sv
module octave_bilinear_height_sample_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TILE_LOG2    = 7;
   localparam int FRAC_BITS    = 12;
   localparam int OCTAVE_SHIFT = 3;
   localparam int PACK_LIMIT   = 8;
   localparam int TILE_SIDE    = 1 << TILE_LOG2;
   localparam int TILE_AREA    = 1 << (2 * TILE_LOG2);
   localparam int STORE_DEPTH  = PACK_LIMIT * TILE_AREA;
   localparam int SIDE_MASK    = TILE_SIDE - 1;
   localparam int FRAC_MASK    = (1 << FRAC_BITS) - 1;
   localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

   // covers the longest sample at the pack limit, with slack past it
   localparam int DRAIN_CYCLES = 5 * PACK_LIMIT + 10;
   localparam int PHASE_ITEMS  = 36;
   localparam int POOL_SIZE    = 8;
   localparam int MAX_REPORTS  = 10;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef struct {
      logic                              action;
      logic [obhs_pkg::ADDR_W-1:0]       entry_address;
      logic signed [obhs_pkg::VAL_W-1:0] entry_value;
      logic [obhs_pkg::COORD_W-1:0]      coord_u;
      logic [obhs_pkg::COORD_W-1:0]      coord_v;
   } tile_request_type;

   class height_scoreboard_type;
      logic signed [obhs_pkg::VAL_W-1:0]    noise [STORE_DEPTH];
      logic [obhs_pkg::PACKS_REG_W-1:0]     pack_count;
      longint                               gain;
      logic signed [obhs_pkg::HEIGHT_W-1:0] heights_due [$];
      int                                   mismatches;

      function new();
         pack_count = '0;
         gain       = longint'(obhs_pkg::GAIN_RESET);
         mismatches = 0;
      endfunction

      function void configure(logic [obhs_pkg::CSR_INDEX_W-1:0] index,
                              logic [obhs_pkg::CSR_DATA_W-1:0] data);
         case (index)
            obhs_pkg::CSR_PACK_COUNT:  pack_count = data[obhs_pkg::PACKS_REG_W-1:0];
            obhs_pkg::CSR_HEIGHT_GAIN: gain = {32'd0, data};
            default: ;
         endcase
      endfunction

      static function longint blend(longint a, longint b, longint f);
         return ((FRAC_ONE - f) * a + f * b) >>> FRAC_BITS;
      endfunction

      function logic signed [obhs_pkg::HEIGHT_W-1:0] sample_height(
            logic [obhs_pkg::COORD_W-1:0] u, logic [obhs_pkg::COORD_W-1:0] v);
         longint acc, top, bot, scaled, fu, fv;
         int     packs, p, c0, c1, r0, r1, base;
         acc   = 0;
         packs = (pack_count > PACK_LIMIT) ? PACK_LIMIT : int'(pack_count);
         for (p = 0; p < packs; p++) begin
            c0   = int'(u >> FRAC_BITS) & SIDE_MASK;
            c1   = (c0 + 1) & SIDE_MASK;
            r0   = int'(v >> FRAC_BITS) & SIDE_MASK;
            r1   = (r0 + 1) & SIDE_MASK;
            fu   = longint'(u & FRAC_MASK);
            fv   = longint'(v & FRAC_MASK);
            base = p * TILE_AREA;
            top  = blend(noise[base + r0 * TILE_SIDE + c0], noise[base + r0 * TILE_SIDE + c1], fu);
            bot  = blend(noise[base + r1 * TILE_SIDE + c0], noise[base + r1 * TILE_SIDE + c1], fu);
            acc += blend(top, bot, fv);
            u    = u << OCTAVE_SHIFT;
            v    = v << OCTAVE_SHIFT;
         end
         scaled = (acc * gain) >>> obhs_pkg::GAIN_FRAC;
         if (scaled > longint'(obhs_pkg::HEIGHT_MAX)) scaled = longint'(obhs_pkg::HEIGHT_MAX);
         if (scaled < longint'(obhs_pkg::HEIGHT_MIN)) scaled = longint'(obhs_pkg::HEIGHT_MIN);
         return scaled[obhs_pkg::HEIGHT_W-1:0];
      endfunction

      function void note_request(tile_request_type r);
         if (r.action == ACTION_SAMPLE)
            heights_due.push_back(sample_height(r.coord_u, r.coord_v));
         else if (r.entry_address < STORE_DEPTH)
            noise[r.entry_address] = r.entry_value;
      endfunction

      function void check_height(logic signed [obhs_pkg::HEIGHT_W-1:0] height);
         logic signed [obhs_pkg::HEIGHT_W-1:0] due;
         if (heights_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: height %0d arrived with no sample pending", $time, height);
         end else begin
            due = heights_due.pop_front();
            if (height !== due) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: height mismatch: expected %0d, got %0d", $time, due, height);
            end
         end
      endfunction

      function int pending();
         return heights_due.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [obhs_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [obhs_pkg::CSR_DATA_W-1:0]   csr_write_data;
   bit                                no_idle;
   bit                                written [STORE_DEPTH];
   int                                touched [$];
   logic [obhs_pkg::COORD_W-1:0]      pool_u [POOL_SIZE];
   logic [obhs_pkg::COORD_W-1:0]      pool_v [POOL_SIZE];

   height_scoreboard_type sb;

   obhs_req_if req_chan();
   obhs_rsp_if rsp_chan();

   octave_bilinear_height_sample_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            sb.configure(csr_index, csr_write_data);
         if (req_chan.valid && req_chan.ready)
            sb.note_request('{req_chan.action, req_chan.entry_address, req_chan.entry_value,
                              req_chan.coord_u, req_chan.coord_v});
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_height(rsp_chan.height);
      end
   end

   // receiver: stall a random number of cycles before each transaction unless no_idle is set
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   function automatic tile_request_type make_request(logic action,
                                                     logic [obhs_pkg::ADDR_W-1:0] addr,
                                                     logic signed [obhs_pkg::VAL_W-1:0] value,
                                                     logic [obhs_pkg::COORD_W-1:0] u,
                                                     logic [obhs_pkg::COORD_W-1:0] v);
      tile_request_type r;
      r.action        = action;
      r.entry_address = addr;
      r.entry_value   = value;
      r.coord_u       = u;
      r.coord_v       = v;
      return r;
   endfunction

   function automatic logic signed [obhs_pkg::VAL_W-1:0] random_value();
      case ($urandom_range(0, 15))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         default: return obhs_pkg::VAL_W'($urandom);
      endcase
   endfunction

   function automatic logic [obhs_pkg::COORD_W-1:0] random_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 32'h000f_ffff);
         default: return $urandom;
      endcase
   endfunction

   // samples draw from a small coordinate pool; writes often hit texels that samples read
   function automatic tile_request_type random_request();
      logic                        action;
      int                          k;
      logic [obhs_pkg::ADDR_W-1:0] addr;
      action = ($urandom_range(0, 99) < 55) ? ACTION_SAMPLE : ACTION_WRITE;
      k      = $urandom_range(0, POOL_SIZE - 1);
      if (touched.size() > 0 && $urandom_range(0, 1) == 1)
         addr = obhs_pkg::ADDR_W'(touched[$urandom_range(0, touched.size() - 1)]);
      else
         addr = obhs_pkg::ADDR_W'($urandom);
      return make_request(action, addr, random_value(), pool_u[k], pool_v[k]);
   endfunction

   task automatic send_request(input tile_request_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.action        <= r.action;
      req_chan.entry_address <= r.entry_address;
      req_chan.entry_value   <= r.entry_value;
      req_chan.coord_u       <= r.coord_u;
      req_chan.coord_v       <= r.coord_v;
      do @(posedge clock); while (!req_chan.ready);
      if (r.action == ACTION_WRITE)
         written[r.entry_address] = 1'b1;
   endtask

   task automatic send_write(input int addr, input logic signed [obhs_pkg::VAL_W-1:0] value);
      send_request(make_request(ACTION_WRITE, obhs_pkg::ADDR_W'(addr), value, '1, '1));
   endtask

   // write every texel a sample at (u, v) could read that holds no value yet
   task automatic fill_texels(input logic [obhs_pkg::COORD_W-1:0] u,
                              input logic [obhs_pkg::COORD_W-1:0] v);
      int p, k, c0, c1, r0, r1, base;
      int addr [4];
      for (p = 0; p < PACK_LIMIT; p++) begin
         c0      = int'(u >> FRAC_BITS) & SIDE_MASK;
         c1      = (c0 + 1) & SIDE_MASK;
         r0      = int'(v >> FRAC_BITS) & SIDE_MASK;
         r1      = (r0 + 1) & SIDE_MASK;
         base    = p * TILE_AREA;
         addr[0] = base + r0 * TILE_SIDE + c0;
         addr[1] = base + r0 * TILE_SIDE + c1;
         addr[2] = base + r1 * TILE_SIDE + c0;
         addr[3] = base + r1 * TILE_SIDE + c1;
         for (k = 0; k < 4; k++) begin
            if (!written[addr[k]]) begin
               touched.push_back(addr[k]);
               send_write(addr[k], random_value());
            end
         end
         u = u << OCTAVE_SHIFT;
         v = v << OCTAVE_SHIFT;
      end
   endtask

   task automatic send_sample(input logic [obhs_pkg::COORD_W-1:0] u,
                              input logic [obhs_pkg::COORD_W-1:0] v);
      fill_texels(u, v);
      send_request(make_request(ACTION_SAMPLE, '1, '1, u, v));
   endtask

   // hold off until every height is back and the sequencer has gone quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [obhs_pkg::PACKS_REG_W-1:0] packs,
                             input logic [obhs_pkg::CSR_DATA_W-1:0] gain_word);
      csr_write_enable <= 1'b1;
      csr_index        <= obhs_pkg::CSR_PACK_COUNT;
      csr_write_data   <= ($urandom & 32'hffff_fff0) | packs;
      @(posedge clock);
      csr_index        <= obhs_pkg::CSR_HEIGHT_GAIN;
      csr_write_data   <= gain_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int                              i, ph, n;
      logic [obhs_pkg::CSR_DATA_W-1:0] gain_word;
      tile_request_type                r;
      sb = new();
      no_idle                = 1'b0;
      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_index              <= obhs_pkg::CSR_PACK_COUNT;
      csr_write_data         <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.action        <= ACTION_WRITE;
      req_chan.entry_address <= '0;
      req_chan.entry_value   <= '0;
      req_chan.coord_u       <= '0;
      req_chan.coord_v       <= '0;
      for (i = 0; i < POOL_SIZE; i++) begin
         pool_u[i] = random_coord();
         pool_v[i] = random_coord();
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pack count is zero out of reset: no texel is read, height is zero
      send_sample('1, '0);
      send_sample('0, '1);
      settle();

      // corners of the first tile, last entry, wrap of column and row
      set_config(obhs_pkg::PACKS_REG_W'(PACK_LIMIT), obhs_pkg::GAIN_RESET);
      send_write(0, 16'sh7fff);
      send_write(1, 16'sh8000);
      send_write(TILE_SIDE, 16'sh8000);
      send_write(TILE_SIDE + 1, 16'sh7fff);
      send_write(STORE_DEPTH - 1, 16'sh8000);
      send_sample(32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0800, 32'h0000_0800);
      send_sample(32'hffff_ffff, 32'hffff_ffff);
      send_sample(32'h0007_ffff, 32'h0000_0fff);
      settle();

      // drive the scaled sum past both rails
      set_config(4'd2, 32'hffff_ffff);
      send_write(0, 16'sh7fff);
      send_write(TILE_AREA, 16'sh7fff);
      send_sample('0, '0);
      send_write(0, 16'sh8000);
      send_write(TILE_AREA, 16'sh8000);
      send_sample('0, '0);
      settle();

      // pack count above the limit clamps to the limit
      set_config(4'hf, obhs_pkg::GAIN_RESET);
      send_sample(pool_u[0], pool_v[0]);
      settle();

      set_config(obhs_pkg::PACKS_REG_W'(PACK_LIMIT), '0);
      send_sample(pool_u[1], pool_v[1]);
      settle();

      for (ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 3))
            0:       gain_word = '0;
            1:       gain_word = '1;
            2:       gain_word = $urandom;
            default: gain_word = $urandom_range(0, 32'h0004_0000);
         endcase
         if (ph == 0)
            set_config(obhs_pkg::PACKS_REG_W'(PACK_LIMIT), obhs_pkg::GAIN_RESET);
         else
            set_config(obhs_pkg::PACKS_REG_W'($urandom_range(0, 15)), gain_word);
         no_idle = (ph % 4 == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = random_request();
            if (r.action == ACTION_SAMPLE)
               send_sample(r.coord_u, r.coord_v);
            else
               send_request(r);
         end
         settle();
      end
      no_idle = 1'b0;

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
